FILE: rtl/core/vptw_pkg.sv
// ----------------------------------------------------------------------------
// vptw_pkg
// Shared types, constants and saturation helper for the vertex projector.
// ----------------------------------------------------------------------------
package vptw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WIDE_W        = 66;

  typedef enum logic [1:0] {
    CFG_VP_LEFT   = 2'd0,
    CFG_VP_BOTTOM = 2'd1,
    CFG_VP_SPAN_X = 2'd2,
    CFG_VP_SPAN_Y = 2'd3
  } cfg_idx_t;

  localparam logic [14:0] VP_SPAN_X_RST = 15'd640;
  localparam logic [14:0] VP_SPAN_Y_RST = 15'd480;

  // Per-request flags carried alongside the divider lanes
  typedef struct packed {
    logic       valid;
    logic       w_zero;
    logic       sat;
    logic [2:0] neg;
  } side_t;

  // Returns {saturated, value}
  function automatic logic [32:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    logic [32:0]              res;
    hi = WIDE_W'(64'sh7FFF_FFFF);
    lo = -WIDE_W'(64'sh8000_0000);
    if (v > hi) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < lo) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/vptw_clip.sv
// ----------------------------------------------------------------------------
// vptw_clip
// Matrix store and two-stage object-to-clip transform (products, then sums).
// ----------------------------------------------------------------------------
module vptw_clip #(
  parameter int FRAC_BITS = vptw_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                acc,
  input  logic                op,
  input  logic [3:0]          entry_index,
  input  logic signed [31:0]  entry_value,
  input  logic signed [31:0]  obj_x,
  input  logic signed [31:0]  obj_y,
  input  logic signed [31:0]  obj_z,
  output logic                clip_valid,
  output logic                clip_sat,
  output logic signed [31:0]  clip_c [4]
);

  localparam int W = vptw_pkg::WIDE_W;

  logic signed [31:0] mat_r [16];
  logic signed [63:0] prod_r [12];
  logic signed [31:0] m3_r [4];
  logic               v1_r;
  logic signed [31:0] clip_r [4];
  logic               sat_r;
  logic               v2_r;
  logic signed [31:0] obj [3];
  logic signed [31:0] clip_nxt [4];
  logic               sat_nxt;

  assign obj[0] = obj_x;
  assign obj[1] = obj_y;
  assign obj[2] = obj_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat_r[i] <= '0;
    end else if (acc && !op) begin
      mat_r[entry_index] <= entry_value;
    end
  end

  // Stage 1: twelve products against the matrix as of acceptance
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) prod_r[r*3+c] <= mat_r[r*4+c] * obj[c];
        m3_r[r] <= mat_r[r*4+3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc && op;
      v2_r <= v1_r;
    end
  end

  // Stage 2: floor-shift each product, sum with the offset column, saturate
  always_comb begin
    logic signed [W-1:0] sum;
    logic [32:0]         s;
    sat_nxt = 1'b0;
    for (int r = 0; r < 4; r++) begin
      sum = W'(m3_r[r]);
      for (int c = 0; c < 3; c++) sum = sum + W'(prod_r[r*3+c] >>> FRAC_BITS);
      s = vptw_pkg::sat32(sum);
      clip_nxt[r] = s[31:0];
      sat_nxt = sat_nxt | s[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clip_r <= clip_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign clip_valid = v2_r;
  assign clip_sat   = sat_r;
  assign clip_c     = clip_r;

endmodule

FILE: rtl/core/vptw_div.sv
// ----------------------------------------------------------------------------
// vptw_div
// Pipelined restoring divider: |num| << FRAC_BITS over |den|, one bit a stage.
// ----------------------------------------------------------------------------
module vptw_div #(
  parameter int FRAC_BITS = vptw_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [31:0]          num,
  input  logic signed [31:0]          den,
  output logic [32+FRAC_BITS-1:0]     quo
);

  localparam int DW = 32 + FRAC_BITS;

  logic [DW-1:0] dvd_r [DW+1];
  logic [DW-1:0] q_r   [DW+1];
  logic [31:0]   rem_r [DW+1];
  logic [31:0]   dv_r  [DW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_r[0] <= {(num[31] ? 32'(-num) : 32'(num)), FRAC_BITS'(0)};
      dv_r[0]  <= den[31] ? 32'(-den) : 32'(den);
      rem_r[0] <= '0;
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < DW; i++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    assign trial = {rem_r[i], dvd_r[i][DW-1]};
    assign diff  = trial - {1'b0, dv_r[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[i+1] <= {dvd_r[i][DW-2:0], 1'b0};
        dv_r[i+1]  <= dv_r[i];
        if (trial >= {1'b0, dv_r[i]}) begin
          rem_r[i+1] <= diff[31:0];
          q_r[i+1]   <= {q_r[i][DW-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= trial[31:0];
          q_r[i+1]   <= {q_r[i][DW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[DW];

endmodule

FILE: rtl/core/vptw_map.sv
// ----------------------------------------------------------------------------
// vptw_map
// Signs and saturates quotients, maps to 0..1, scales by viewport, registers out.
// ----------------------------------------------------------------------------
module vptw_map #(
  parameter int FRAC_BITS = vptw_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  vptw_pkg::side_t          side,
  input  logic [32+FRAC_BITS-1:0]  quo [3],
  input  logic [13:0]              vp_left,
  input  logic [13:0]              vp_bottom,
  input  logic [14:0]              vp_span_x,
  input  logic [14:0]              vp_span_y,
  output logic                     out_valid,
  output logic signed [31:0]       win_x,
  output logic signed [31:0]       win_y,
  output logic signed [31:0]       win_z,
  output logic                     w_was_zero,
  output logic                     saturated
);

  localparam int W  = vptw_pkg::WIDE_W;
  localparam int DW = 32 + FRAC_BITS;
  localparam logic signed [31:0] HALF = 32'sd1 <<< (FRAC_BITS - 1);

  vptw_pkg::side_t    s1_r, s2_r;
  logic signed [31:0] ndc_r [3];
  logic signed [31:0] t_z_r;
  logic signed [47:0] px_r, py_r;
  logic signed [31:0] ndc_nxt [3];
  logic               ndc_sat;
  logic signed [31:0] t [3];
  logic               v3_r;
  logic signed [31:0] wx_r, wy_r, wz_r;
  logic               wzero_r, sat_r;
  logic [32:0]        sx, sy;

  // Apply quotient sign and clamp to 32 bits
  always_comb begin
    logic signed [DW:0] sv;
    logic [32:0]        s;
    ndc_sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sv = side.neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
      s  = vptw_pkg::sat32(W'(sv));
      ndc_nxt[k] = s[31:0];
      ndc_sat = ndc_sat | s[32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ndc_r     <= ndc_nxt;
      s1_r.neg  <= side.neg;
      s1_r.w_zero <= side.w_zero;
      s1_r.sat  <= side.sat | (!side.w_zero && ndc_sat);
    end
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (en) begin
      s1_r.valid <= side.valid;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) t[k] = (ndc_r[k] >>> 1) + HALF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r  <= t[0] * $signed({1'b0, vp_span_x});
      py_r  <= t[1] * $signed({1'b0, vp_span_y});
      t_z_r <= t[2];
      s2_r.neg    <= s1_r.neg;
      s2_r.w_zero <= s1_r.w_zero;
      s2_r.sat    <= s1_r.sat;
    end
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (en) begin
      s2_r.valid <= s1_r.valid;
    end
  end

  assign sx = vptw_pkg::sat32(W'(px_r) + (W'(vp_left) <<< FRAC_BITS));
  assign sy = vptw_pkg::sat32(W'(py_r) + (W'(vp_bottom) <<< FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      wzero_r <= s2_r.w_zero;
      if (s2_r.w_zero) begin
        wx_r  <= '0;
        wy_r  <= '0;
        wz_r  <= '0;
        sat_r <= s2_r.sat;
      end else begin
        wx_r  <= sx[31:0];
        wy_r  <= sy[31:0];
        wz_r  <= t_z_r;
        sat_r <= s2_r.sat | sx[32] | sy[32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= s2_r.valid;
    end
  end

  assign out_valid  = v3_r;
  assign win_x      = wx_r;
  assign win_y      = wy_r;
  assign win_z      = wz_r;
  assign w_was_zero = wzero_r;
  assign saturated  = sat_r;

endmodule

FILE: rtl/core/vertex_project_to_window_unit.sv
// A vertex request passes the clip, divider and map registers; Q16.16 at FRAC_BITS 16.
// Throughput: one request per cycle unless a held result stalls the pipeline;
// the divider lanes retire one quotient bit per stage. Matrix loads produce no result.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, synchronous): matrix cleared, viewport 0,0,640,480, pipeline empty.
// ----------------------------------------------------------------------------
// vertex_project_to_window_unit
// Object-to-window vertex projector: matrix transform, divide by w, viewport map.
// ----------------------------------------------------------------------------
module vertex_project_to_window_unit #(
  parameter int FRAC_BITS = vptw_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [3:0]         in_entry_index,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_obj_x,
  input  logic signed [31:0] in_obj_y,
  input  logic signed [31:0] in_obj_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_win_x,
  output logic signed [31:0] out_win_y,
  output logic signed [31:0] out_win_z,
  output logic               out_w_was_zero,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  localparam int DW = 32 + FRAC_BITS;

  logic               en;
  logic               acc;
  logic [13:0]        vp_left_r, vp_bottom_r;
  logic [14:0]        vp_span_x_r, vp_span_y_r;
  logic               clip_valid, clip_sat;
  logic signed [31:0] clip_c [4];
  logic [DW-1:0]      quo [3];
  vptw_pkg::side_t    side_in;
  vptw_pkg::side_t    side_r [DW+1];

  // Advance everything unless a finished result is held
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign acc       = in_valid && en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_left_r   <= '0;
      vp_bottom_r <= '0;
      vp_span_x_r <= vptw_pkg::VP_SPAN_X_RST;
      vp_span_y_r <= vptw_pkg::VP_SPAN_Y_RST;
    end else if (cfg_valid) begin
      case (vptw_pkg::cfg_idx_t'(cfg_index))
        vptw_pkg::CFG_VP_LEFT:   vp_left_r   <= cfg_data[13:0];
        vptw_pkg::CFG_VP_BOTTOM: vp_bottom_r <= cfg_data[13:0];
        vptw_pkg::CFG_VP_SPAN_X: vp_span_x_r <= cfg_data;
        vptw_pkg::CFG_VP_SPAN_Y: vp_span_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vptw_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .acc         (acc),
    .op          (in_op),
    .entry_index (in_entry_index),
    .entry_value (in_entry_value),
    .obj_x       (in_obj_x),
    .obj_y       (in_obj_y),
    .obj_z       (in_obj_z),
    .clip_valid  (clip_valid),
    .clip_sat    (clip_sat),
    .clip_c      (clip_c)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    vptw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (clip_c[k]),
      .den (clip_c[3]),
      .quo (quo[k])
    );
  end

  always_comb begin
    side_in.valid  = clip_valid;
    side_in.w_zero = (clip_c[3] == '0);
    side_in.sat    = clip_sat;
    for (int k = 0; k < 3; k++) side_in.neg[k] = clip_c[k][31] ^ clip_c[3][31];
  end

  // Flags ride alongside the divider, matched to its latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DW; i++) side_r[i] <= '0;
    end else if (en) begin
      side_r[0] <= side_in;
      for (int i = 0; i < DW; i++) side_r[i+1] <= side_r[i];
    end
  end

  vptw_map #(.FRAC_BITS(FRAC_BITS)) u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .side       (side_r[DW]),
    .quo        (quo),
    .vp_left    (vp_left_r),
    .vp_bottom  (vp_bottom_r),
    .vp_span_x  (vp_span_x_r),
    .vp_span_y  (vp_span_y_r),
    .out_valid  (out_valid),
    .win_x      (out_win_x),
    .win_y      (out_win_y),
    .win_z      (out_win_z),
    .w_was_zero (out_w_was_zero),
    .saturated  (out_saturated)
  );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vertex projector: loads transform matrices,
// projects vertices under several viewports and idle patterns, and compares
// each window-space result against an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module tb;

  localparam int  FRAC       = vptw_pkg::FRAC_BITS_DEF;
  localparam int  LATENCY    = 60;
  localparam int  STALL_LIMIT = 5000;
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  typedef struct {
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
    logic signed [31:0] win_z;
    logic               w_zero;
    logic               sat;
  } window_pt_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_op;
  logic [3:0]         in_entry_index;
  logic signed [31:0] in_entry_value;
  logic signed [31:0] in_obj_x;
  logic signed [31:0] in_obj_y;
  logic signed [31:0] in_obj_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_win_x;
  logic signed [31:0] out_win_y;
  logic signed [31:0] out_win_z;
  logic               out_w_was_zero;
  logic               out_saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [14:0]        cfg_data;

  // bench copy of the block state
  logic signed [31:0] xform [16];
  longint             vp_left, vp_bottom, vp_span_x, vp_span_y;

  window_pt_t pending_pts[$];
  int  errors;
  int  vertices_sent, loads_sent, points_checked;
  int  send_idle_pct, recv_stall_pct;
  int  quiet_cycles;

  vertex_project_to_window_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint clamp32(longint v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic window_pt_t project_vertex(logic signed [31:0] ox,
                                                logic signed [31:0] oy,
                                                logic signed [31:0] oz);
    window_pt_t p;
    longint obj[3];
    longint clip[4];
    longint t[3];
    longint acc;
    logic   sat;
    sat = 1'b0;
    obj[0] = ox;
    obj[1] = oy;
    obj[2] = oz;
    for (int r = 0; r < 4; r++) begin
      acc = longint'(xform[r*4+3]);
      for (int c = 0; c < 3; c++)
        acc += (longint'(xform[r*4+c]) * obj[c]) >>> FRAC;
      clip[r] = clamp32(acc, sat);
    end
    if (clip[3] == 0) begin
      p.win_x = '0;
      p.win_y = '0;
      p.win_z = '0;
      p.w_zero = 1'b1;
      p.sat = sat;
      return p;
    end
    for (int r = 0; r < 3; r++)
      t[r] = (clamp32((clip[r] <<< FRAC) / clip[3], sat) >>> 1) + (64'sd1 <<< (FRAC - 1));
    p.win_x = 32'(clamp32(t[0] * vp_span_x + (vp_left <<< FRAC), sat));
    p.win_y = 32'(clamp32(t[1] * vp_span_y + (vp_bottom <<< FRAC), sat));
    p.win_z = 32'(clamp32(t[2], sat));
    p.w_zero = 1'b0;
    p.sat = sat;
    return p;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_request(logic op, logic [3:0] idx, logic signed [31:0] val,
                              logic signed [31:0] ox, logic signed [31:0] oy,
                              logic signed [31:0] oz);
    // decide on idling afresh before each clock so the idle share matches the percentage
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_obj_x       <= ox;
    in_obj_y       <= oy;
    in_obj_z       <= oz;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      xform[idx] = val;
      loads_sent++;
    end else begin
      pending_pts.push_back(project_vertex(ox, oy, oz));
      vertices_sent++;
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pts.size() != 0) @(posedge clk);
    // loads after the last vertex may still be in flight
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(vptw_pkg::cfg_idx_t idx, logic [14:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vptw_pkg::CFG_VP_LEFT:   vp_left   = data[13:0];
      vptw_pkg::CFG_VP_BOTTOM: vp_bottom = data[13:0];
      vptw_pkg::CFG_VP_SPAN_X: vp_span_x = data;
      vptw_pkg::CFG_VP_SPAN_Y: vp_span_y = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_viewport(logic [14:0] l, logic [14:0] b, logic [14:0] sx,
                              logic [14:0] sy);
    drain_pipeline();
    write_reg(vptw_pkg::CFG_VP_LEFT, l);
    write_reg(vptw_pkg::CFG_VP_BOTTOM, b);
    write_reg(vptw_pkg::CFG_VP_SPAN_X, sx);
    write_reg(vptw_pkg::CFG_VP_SPAN_Y, sy);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $signed($urandom_range(32'h3FFFF)) - 32'sh20000;
      2:       return $signed($urandom_range(32'hFFFFFF)) - 32'sh800000;
      default: return $signed($urandom_range(32'h1FFF)) - 32'sh1000;
    endcase
  endfunction

  task automatic load_identity();
    for (int i = 0; i < 16; i++)
      send_request(OP_LOAD, 4'(i), (i % 5 == 0) ? 32'sh10000 : 32'sh0, '0, '0, '0);
  endtask

  task automatic test_directed();
    // cleared matrix gives zero w
    send_request(OP_PROJECT, '0, '0, 32'sh10000, 32'sh10000, 32'sh10000);
    load_identity();
    send_request(OP_PROJECT, '0, '0, '0, '0, '0);
    send_request(OP_PROJECT, '0, '0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_request(OP_PROJECT, '0, '0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send_request(OP_PROJECT, '0, '0, 32'sh10000, -32'sh10000, 32'sh8000);
    // saturate the clip stage, then drive w to both saturation limits and to one LSB
    send_request(OP_LOAD, 4'd0, 32'sh7FFFFFFF, '0, '0, '0);
    send_request(OP_LOAD, 4'd1, 32'sh7FFFFFFF, '0, '0, '0);
    send_request(OP_PROJECT, '0, '0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, '0);
    send_request(OP_LOAD, 4'd15, 32'sh80000000, '0, '0, '0);
    send_request(OP_LOAD, 4'd12, 32'sh80000000, '0, '0, '0);
    send_request(OP_PROJECT, '0, '0, 32'sh10000, '0, '0);
    send_request(OP_PROJECT, '0, '0, 32'sh80000000, '0, '0);
    send_request(OP_LOAD, 4'd15, 32'sh1, '0, '0, '0);
    send_request(OP_LOAD, 4'd12, 32'sh0, '0, '0, '0);
    send_request(OP_PROJECT, '0, '0, 32'sh10000, 32'sh7FFF, 32'sh1);
    // zero spans: output is the viewport offset alone
    set_viewport(15'h7FFF, 15'h3FFF, 15'd0, 15'd0);
    send_request(OP_PROJECT, '0, '0, 32'sh10000, 32'sh20000, '0);
    set_viewport(15'h3FFF, 15'd0, 15'd16384, 15'd16384);
    send_request(OP_PROJECT, '0, '0, 32'sh1234, -32'sh4321, 32'sh8000);
    send_request(OP_PROJECT, '0, '0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    drain_pipeline();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    case ($urandom_range(2))
      0: set_viewport(15'($urandom), 15'($urandom), 15'($urandom_range(1, 16384)),
                      15'($urandom_range(1, 16384)));
      1: set_viewport(15'd0, 15'd0, 15'd1, 15'd1);
      default: set_viewport(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
    endcase
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        // reload a whole perspective-like matrix
        for (int i = 0; i < 16; i++)
          send_request(OP_LOAD, 4'(i),
                       (i == 15 && $urandom_range(3) != 0) ? 32'sh10000 + rand_q() : rand_q(),
                       $urandom, $urandom, $urandom);
        n += 15;
      end else if ($urandom_range(9) == 0) begin
        send_request(OP_LOAD, 4'($urandom), rand_q(), $urandom, $urandom, $urandom);
      end else begin
        send_request(OP_PROJECT, 4'($urandom), $urandom, rand_q(), rand_q(), rand_q());
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    window_pt_t exp_pt;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected result win_x=%h win_y=%h win_z=%h", $time,
                 out_win_x, out_win_y, out_win_z);
        errors++;
      end else begin
        exp_pt = pending_pts.pop_front();
        points_checked++;
        if (out_win_x !== exp_pt.win_x) begin
          $display("%0t: win_x expected %h actual %h", $time, exp_pt.win_x, out_win_x);
          errors++;
        end
        if (out_win_y !== exp_pt.win_y) begin
          $display("%0t: win_y expected %h actual %h", $time, exp_pt.win_y, out_win_y);
          errors++;
        end
        if (out_win_z !== exp_pt.win_z) begin
          $display("%0t: win_z expected %h actual %h", $time, exp_pt.win_z, out_win_z);
          errors++;
        end
        if (out_w_was_zero !== exp_pt.w_zero) begin
          $display("%0t: w_was_zero expected %b actual %b", $time, exp_pt.w_zero,
                   out_w_was_zero);
          errors++;
        end
        if (out_saturated !== exp_pt.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, exp_pt.sat,
                   out_saturated);
          errors++;
        end
      end
    end
  end

  // watchdog: count cycles with no request moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    vertices_sent = 0;
    loads_sent = 0;
    points_checked = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 16; i++) xform[i] = '0;
    vp_left = 0;
    vp_bottom = 0;
    vp_span_x = 640;
    vp_span_y = 480;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_LOAD;
    in_entry_index <= '0;
    in_entry_value <= '0;
    in_obj_x <= '0;
    in_obj_y <= '0;
    in_obj_z <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= vptw_pkg::CFG_VP_LEFT;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(0, 0, 460);
    test_random_phase(46, 0, 460);
    test_random_phase(0, 46, 460);
    test_random_phase(33, 33, 460);
    drain_pipeline();

    $display("Sent %0d vertices and %0d matrix loads; checked %0d window points.",
             vertices_sent, loads_sent, points_checked);
    $display("Viewports swept incl. zero and full spans; idle and stall mixes applied.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
